@@ hw/rtl/krd_pkg.sv @@
package krd_pkg;

    // List geometry
    localparam int LIST_DEPTH = 16;
    localparam int PTR_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int TAG_W      = 16;
    localparam int MODE_W     = 3;
    localparam int ST_W       = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEXT_AFTER = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // One stored entry
    typedef struct packed {
        logic [TAG_W-1:0] id;
        logic [TAG_W-1:0] holder;
        logic [TAG_W-1:0] ride;
    } t_entry;

    // Ring slot of list position pos; front < depth and pos <= depth
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(front) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(LIST_DEPTH)) begin
            sum = sum - (CNT_W+1)'(LIST_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/krd_ram.sv @@
module krd_ram
    import krd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [PTR_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [LIST_DEPTH];
    t_entry r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/keyed_ring_deque_unit.sv @@
// Bounded ordered list of up to LIST_DEPTH entries (id plus two 16-bit handles)
// kept in a ring buffer with one write and one registered read port. One request
// is handled at a time; o_stall is high from acceptance until the result has been
// loaded into the output register, which then waits for the sink independently.
// Lookup, next-after and remove scan from the front one entry per cycle
// through the single RAM read port. Remove then moves every later entry up
// one slot, one entry per cycle on the same port.
module keyed_ring_deque_unit
    import krd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [TAG_W-1:0]  i_key_id,
    input  logic [TAG_W-1:0]  i_holder_tag,
    input  logic [TAG_W-1:0]  i_ride_tag,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [TAG_W-1:0]  o_entry_id,
    output logic [TAG_W-1:0]  o_entry_holder,
    output logic [TAG_W-1:0]  o_entry_ride,
    output logic [CNT_W-1:0]  o_entry_count
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_ENTRY_RD = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [TAG_W-1:0]  r_key, n_key;
    logic [TAG_W-1:0]  r_hold, n_hold;
    logic [TAG_W-1:0]  r_ride, n_ride;
    logic [PTR_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_dv, n_dv;
    logic [CNT_W-1:0]  r_dpos, n_dpos;
    logic [ST_W-1:0]   r_st, n_st;
    t_entry            r_res, n_res;

    logic              r_ovalid;
    logic [ST_W-1:0]   r_ostatus;
    t_entry            r_oentry;
    logic [CNT_W-1:0]  r_ocount;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic [PTR_W-1:0]  ram_raddr;
    t_entry            ram_rdata;

    logic              out_load;
    logic [PTR_W-1:0]  front_dec;
    logic [PTR_W-1:0]  front_inc;
    logic [CNT_W-1:0]  dpos_inc;

    krd_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign front_dec = (r_front == '0) ? PTR_W'(LIST_DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == PTR_W'(LIST_DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign dpos_inc  = r_dpos + 1'b1;

    assign o_stall  = (r_state != S_IDLE);
    assign out_load = (r_state == S_FIN) && (!r_ovalid || !i_stall);

    // Request sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_hold    = r_hold;
        n_ride    = r_ride;
        n_front   = r_front;
        n_count   = r_count;
        n_pos     = r_pos;
        n_dv      = r_dv;
        n_dpos    = r_dpos;
        n_st      = r_st;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = slot_of(r_front, r_count);
        ram_wdata = '{id: r_key, holder: r_hold, ride: r_ride};
        ram_raddr = slot_of(r_front, r_pos);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_key   = i_key_id;
                    n_hold  = i_holder_tag;
                    n_ride  = i_ride_tag;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_st    = ST_MISS;
                n_res   = '0;
                n_pos   = '0;
                n_dv    = 1'b0;
                n_state = S_FIN;
                unique case (r_mode) inside
                    MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                        if (r_count == CNT_W'(LIST_DEPTH)) begin
                            n_st = ST_FULL;
                        end else begin
                            ram_we = 1'b1;
                            if (r_mode == MODE_PUSH_FRONT) begin
                                ram_waddr = front_dec;
                                n_front   = front_dec;
                            end
                            n_count = r_count + 1'b1;
                            n_st    = ST_OK;
                        end
                    end
                    MODE_POP_FRONT: begin
                        if (r_count != '0) begin
                            ram_raddr = r_front;
                            n_front   = (r_count == CNT_W'(1)) ? '0 : front_inc;
                            n_count   = r_count - 1'b1;
                            n_state   = S_ENTRY_RD;
                        end
                    end
                    MODE_REMOVE, MODE_LOOKUP, MODE_NEXT_AFTER: begin
                        if (r_count != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            // one read issued per cycle; compare the entry read last cycle
            S_SCAN: begin
                n_pos  = r_pos + 1'b1;
                n_dv   = 1'b1;
                n_dpos = r_pos;
                if (r_dv) begin
                    if (ram_rdata.id == r_key) begin
                        n_st = ST_OK;
                        if (r_mode == MODE_NEXT_AFTER) begin
                            ram_raddr = slot_of(r_front,
                                                (dpos_inc < r_count) ? dpos_inc : '0);
                            n_state   = S_ENTRY_RD;
                        end else if (r_mode == MODE_REMOVE) begin
                            n_res   = ram_rdata;
                            n_pos   = dpos_inc;
                            n_dv    = 1'b0;
                            n_state = S_SHIFT;
                        end else begin
                            n_res   = ram_rdata;
                            n_state = S_FIN;
                        end
                    end else if (r_dpos == r_count - 1'b1) begin
                        n_state = S_FIN;
                    end
                end
            end
            // close the gap: read position q+1, write it to position q
            S_SHIFT: begin
                n_dv   = (r_pos < r_count);
                n_dpos = r_pos;
                if (r_pos < r_count) begin
                    n_pos = r_pos + 1'b1;
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_front, r_dpos - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (!(r_pos < r_count) && !r_dv) begin
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_front = '0;
                    end
                    n_state = S_FIN;
                end
            end
            S_ENTRY_RD: begin
                n_res   = ram_rdata;
                n_st    = ST_OK;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_dv    <= n_dv;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_key  <= n_key;
        r_hold <= n_hold;
        r_ride <= n_ride;
        r_pos  <= n_pos;
        r_dpos <= n_dpos;
        r_st   <= n_st;
        r_res  <= n_res;
        if (out_load) begin
            r_ostatus <= r_st;
            r_oentry  <= r_res;
            r_ocount  <= r_count;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_entry_id     = r_oentry.id;
    assign o_entry_holder = r_oentry.holder;
    assign o_entry_ride   = r_oentry.ride;
    assign o_entry_count  = r_ocount;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0))
        else $error("empty list with nonzero front index");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DECODE || r_state == S_SHIFT))
        else $error("store written outside push or shift");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DECODE))
        else $error("accepted transaction not decoded");

endmodule
